[hdl/stx_pkg.sv]
// Shared types and constants for the S-expression token scanner.
package stx_pkg;

    localparam int MAX_TEXT = 255;
    localparam int LEN_W    = $clog2(MAX_TEXT + 1);
    localparam int VAL_W    = 31;
    localparam logic [VAL_W-1:0] NUM_MAX = {VAL_W{1'b1}};

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_I   = 8'h49;
    localparam logic [7:0] CH_UP_L   = 8'h4C;
    localparam logic [7:0] CH_UP_N   = 8'h4E;
    localparam logic [7:0] CH_UP_T   = 8'h54;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_STR,
        MODE_ATOM
    } mode_t;

    typedef enum logic [2:0] {
        KW_EMPTY,
        KW_N,
        KW_NI,
        KW_NIL,
        KW_T,
        KW_NONE
    } kw_t;

    typedef enum logic [3:0] {
        KIND_TEXT,
        KIND_NUMBER,
        KIND_STRING,
        KIND_ATOM,
        KIND_NIL,
        KIND_TRUE,
        KIND_LPAREN,
        KIND_RPAREN,
        KIND_QUOTE,
        KIND_END
    } kind_t;

    typedef struct packed {
        mode_t             mode;
        logic [VAL_W-1:0]  value;
        logic [LEN_W-1:0]  length;
        kw_t               kw;
        logic              ovf;
    } scan_state_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        ch;
        logic [VAL_W-1:0]  value;
        logic [7:0]        length;
        logic              ovf;
        logic              last;
    } token_t;

    typedef struct packed {
        logic [1:0]        count;
        token_t [1:0]      tok;
    } lex_out_t;

    function automatic logic [7:0] sat_len(input logic [LEN_W-1:0] l);
        logic [15:0] w;
        w = 16'(l);
        return (w > 16'd255) ? 8'hFF : w[7:0];
    endfunction

endpackage

[hdl/stx_lexer.sv]
// Combinational scanner core: next scan state and up to two tokens for one byte.
module stx_lexer import stx_pkg::*; (
    input  logic        byte_valid,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    input  scan_state_t state,
    output scan_state_t state_next,
    output lex_out_t    lex_out
);

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return ((c >= 8'd33) && (c <= 8'd47)) || ((c >= 8'd58) && (c <= 8'd64)) ||
               ((c >= 8'd91) && (c <= 8'd96)) || ((c >= 8'd123) && (c <= 8'd126));
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
    endfunction

    function automatic kw_t kw_next(input kw_t m, input logic [7:0] c);
        kw_t r;
        r = KW_NONE;
        case (m)
            KW_EMPTY: begin
                if (c == CH_UP_N) r = KW_N;
                else if (c == CH_UP_T) r = KW_T;
            end
            KW_N:    if (c == CH_UP_I) r = KW_NI;
            KW_NI:   if (c == CH_UP_L) r = KW_NIL;
            default: r = KW_NONE;
        endcase
        return r;
    endfunction

    function automatic token_t mk_tok(input kind_t k, input logic [7:0] ch,
                                      input logic [VAL_W-1:0] v,
                                      input logic [7:0] l, input logic o);
        token_t t;
        t.kind   = k;
        t.ch     = ch;
        t.value  = v;
        t.length = l;
        t.ovf    = o;
        t.last   = 1'b0;
        return t;
    endfunction

    logic       is_end, dig, atom_start, atom_term, text_room;
    logic       do_close, do_idle, text_emit, idle_tok;
    logic [7:0] up, text_ch;
    kind_t      idle_kind, close_kind;
    logic [VAL_W+3:0] prod;

    // Shared decode of the byte against the current mode.
    always_comb begin
        is_end     = end_of_input || (in_byte == CH_NUL);
        dig        = is_digit(in_byte);
        up         = upcase(in_byte);
        atom_start = is_alpha(in_byte) || is_punct(in_byte);
        atom_term  = (in_byte == CH_SPACE) || (in_byte == CH_NL) || (in_byte == CH_RPAREN);
        text_room  = 32'(state.length) < MAX_TEXT;
        prod       = (VAL_W+4)'(state.value) * (VAL_W+4)'(10)
                     + (VAL_W+4)'(in_byte - CH_ZERO);

        do_close  = is_end;
        do_idle   = 1'b0;
        text_emit = 1'b0;
        text_ch   = up;
        if (!is_end) begin
            case (state.mode)
                MODE_NUM: begin
                    do_close = !dig;
                    do_idle  = !dig;
                end
                MODE_STR: begin
                    do_close  = (in_byte == CH_DQUOTE);
                    text_emit = (in_byte != CH_DQUOTE) && text_room;
                    text_ch   = in_byte;
                end
                MODE_ATOM: begin
                    do_close  = atom_term;
                    do_idle   = atom_term;
                    text_emit = !atom_term && text_room;
                end
                default: do_idle = 1'b1;
            endcase
        end
        if (do_idle && atom_start && !dig && in_byte != CH_DQUOTE &&
            in_byte != CH_LPAREN && in_byte != CH_RPAREN &&
            in_byte != CH_APOS && in_byte != CH_COLON)
            text_emit = 1'b1;

        idle_tok  = 1'b1;
        idle_kind = KIND_QUOTE;
        if (in_byte == CH_LPAREN) idle_kind = KIND_LPAREN;
        else if (in_byte == CH_RPAREN) idle_kind = KIND_RPAREN;
        else if (in_byte != CH_APOS && in_byte != CH_COLON) idle_tok = 1'b0;

        case (state.kw)
            KW_NIL:  close_kind = KIND_NIL;
            KW_T:    close_kind = KIND_TRUE;
            default: close_kind = KIND_ATOM;
        endcase
    end

    // Next scan state
    always_comb begin
        scan_state_t idle_st;
        idle_st = '{mode: MODE_IDLE, value: '0, length: '0, kw: KW_EMPTY, ovf: 1'b0};
        if (dig) begin
            idle_st.mode   = MODE_NUM;
            idle_st.value  = VAL_W'(in_byte - CH_ZERO);
            idle_st.length = LEN_W'(1);
        end else if (in_byte == CH_DQUOTE) begin
            idle_st.mode = MODE_STR;
        end else if (!idle_tok && atom_start) begin
            idle_st.mode   = MODE_ATOM;
            idle_st.length = LEN_W'(1);
            idle_st.kw     = kw_next(KW_EMPTY, up);
        end

        state_next = state;
        if (!byte_valid) begin
            state_next = state;
        end else if (is_end || do_close) begin
            state_next = idle_st;
            if (is_end || !do_idle) begin
                state_next = '{mode: MODE_IDLE, value: '0, length: '0,
                               kw: KW_EMPTY, ovf: 1'b0};
            end
        end else if (do_idle) begin
            state_next = idle_st;
        end else begin
            case (state.mode)
                MODE_NUM: begin
                    if (prod > (VAL_W+4)'(NUM_MAX)) begin
                        state_next.value = NUM_MAX;
                        state_next.ovf   = 1'b1;
                    end else begin
                        state_next.value = prod[VAL_W-1:0];
                    end
                    if (text_room) state_next.length = state.length + LEN_W'(1);
                    else state_next.ovf = 1'b1;
                end
                MODE_STR, MODE_ATOM: begin
                    if (text_room) begin
                        state_next.length = state.length + LEN_W'(1);
                        if (state.mode == MODE_ATOM) state_next.kw = kw_next(state.kw, up);
                    end else begin
                        state_next.ovf = 1'b1;
                    end
                end
                default: state_next = state;
            endcase
        end
    end

    // Tokens, in emission order
    always_comb begin
        logic [1:0] n;
        token_t     t;
        n = 2'd0;
        lex_out.tok = '0;
        if (do_close && state.mode != MODE_IDLE) begin
            case (state.mode)
                MODE_NUM:  t = mk_tok(KIND_NUMBER, 8'h00, state.value,
                                      sat_len(state.length), state.ovf);
                MODE_STR:  t = mk_tok(KIND_STRING, 8'h00, '0,
                                      sat_len(state.length), state.ovf);
                default:   t = mk_tok(close_kind, 8'h00, '0,
                                      sat_len(state.length), state.ovf);
            endcase
            lex_out.tok[n[0]] = t;
            n = n + 2'd1;
        end
        if (is_end) begin
            lex_out.tok[n[0]] = mk_tok(KIND_END, 8'h00, '0, 8'h00, 1'b0);
            n = n + 2'd1;
        end else if (text_emit) begin
            lex_out.tok[n[0]] = mk_tok(KIND_TEXT, text_ch, '0, 8'h00, 1'b0);
            n = n + 2'd1;
        end else if (do_idle && idle_tok) begin
            lex_out.tok[n[0]] = mk_tok(idle_kind, 8'h00, '0, 8'h00, 1'b0);
            n = n + 2'd1;
        end
        if (n != 2'd0) lex_out.tok[n[0] - 1'b1].last = 1'b1;
        lex_out.count = byte_valid ? n : 2'd0;
    end

endmodule

[hdl/stx_token_queue.sv]
// Small token queue: takes up to two tokens per cycle, hands out one per cycle while out_ready is high.
module stx_token_queue import stx_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  lex_out_t push,
    output logic     room2,
    output logic     out_valid,
    input  logic     out_ready,
    output token_t   out_tok
);

    token_t [QDEPTH-1:0] ent_reg;
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                pop;

    assign out_valid = count_reg != '0;
    assign out_tok   = ent_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room2     = 32'(count_reg) <= QDEPTH - 2;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) ent_reg[wr_ptr_reg] <= push.tok[0];
        if (push.count == 2'd2) ent_reg[wr_ptr_reg + QPTR_W'(1)] <= push.tok[1];
    end

endmodule

[hdl/sexpr_token_scanner.sv]
// Top level of the S-expression token scanner: input register, scan state, token queue.
// Each source byte is held in an input register; once the queue has room for two
// tokens, the scanner core updates the scan state and writes zero, one or two tokens
// into a four-entry token queue, whose head drives the result port. Bytes are taken
// one per cycle as long as the queue has room for two tokens. The result port gives
// one token per cycle while m_tready is high, so a byte that ends a token and also
// yields one of its own (or the end mark) puts two tokens on it. A token reaches the
// port through the input register and the token queue. No clearing pass after reset.
module sexpr_token_scanner import stx_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] text_char, [38:8] number_value,
                                   // [46:39] text_length, [47] overflow
    output logic [3:0]  m_tuser,   // [3:0] kind
    output logic        m_tlast
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  byte_reg;
    logic        eoi_reg;
    scan_state_t state_reg, state_next;
    lex_out_t    lex_out;
    logic        room2, consume;
    token_t      head;

    assign consume  = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || consume;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) in_valid_next = 1'b1;
        else if (consume) in_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{mode: MODE_IDLE, value: '0, length: '0,
                              kw: KW_EMPTY, ovf: 1'b0};
        end else begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
            eoi_reg  <= s_tuser[0];
        end
    end

    stx_lexer u_lexer (
        .byte_valid   (consume),
        .in_byte      (byte_reg),
        .end_of_input (eoi_reg),
        .state        (state_reg),
        .state_next   (state_next),
        .lex_out      (lex_out)
    );

    stx_token_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (lex_out),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (head)
    );

    assign m_tdata = {head.ovf, head.length, head.value, head.ch};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule
